FILE: hdl/jpci_pkg.sv
package jpci_pkg;

    localparam int JOINTS       = 6;
    localparam int MAX_SEGMENTS = 64;
    localparam int ANGLE_W      = 16;
    localparam int DIFF_W       = ANGLE_W + 1;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int PROD_W       = DIFF_W + SEG_W;
    localparam int IDX_W        = 3;
    localparam int QDIV_W       = PROD_W;

    localparam logic [IDX_W-1:0] REG_THRESHOLD = IDX_W'(JOINTS);

    typedef struct packed {
        logic signed [15:0] angle_0;
        logic signed [15:0] angle_1;
        logic signed [15:0] angle_2;
        logic signed [15:0] angle_3;
        logic signed [15:0] angle_4;
        logic signed [15:0] angle_5;
        logic               first_point;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_angle_0;
        logic signed [15:0] out_angle_1;
        logic signed [15:0] out_angle_2;
        logic signed [15:0] out_angle_3;
        logic signed [15:0] out_angle_4;
        logic signed [15:0] out_angle_5;
        logic               interpolated;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic [SEG_W-1:0]   divisor;
        logic [SEG_W-1:0]   k;
    } lane_ctl_t;

endpackage

FILE: hdl/joint_path_clamp_interpolate.sv
// Channel  Direction  Payload        Handshake
// in       input      in_item_t      in_valid / in_ready
// out      output     out_item_t     out_valid / out_ready
// cfg      input      index, data    cfg_valid / cfg_ready
// A first point is registered for output directly; a point within the threshold is clamped and output.
// A larger step first counts its n segments; then, for each interpolated point, the block
// starts the lane dividers, waits while they divide, captures the result and waits for its
// transfer. The clamped point is output after the last interpolated point.
// Reset is asynchronous and restores limits, threshold and the stored point.
// The output register holds a result until transferred; the block waits.
module joint_path_clamp_interpolate
    import jpci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEG  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_SEGW = 3'd5;

    logic [2:0]                  st_reg, st_next;
    logic [31:0]                 lim_reg [JOINTS];
    logic [14:0]                 thr_reg;
    logic signed [ANGLE_W-1:0]   prev_reg [JOINTS];
    logic signed [ANGLE_W-1:0]   cur_reg [JOINTS];
    logic signed [ANGLE_W-1:0]   clamp [JOINTS];
    logic signed [ANGLE_W-1:0]   in_ang [JOINTS];
    logic signed [ANGLE_W-1:0]   lane_pt [JOINTS];
    logic [JOINTS-1:0]           lane_done;
    logic [DIFF_W-1:0]           step_reg, mstep;
    logic [DIFF_W-1:0]           absd [JOINTS];
    logic [SEG_W-1:0]            n_reg, k_reg;
    logic [SEG_W-1:0]            segs;
    logic                        seg_done, seg_start, lane_start;
    logic                        ov_reg;
    out_item_t                   od_reg;
    lane_ctl_t                   ctl;
    logic [14:0]                 t1;

    assign in_ang[0] = in_data.angle_0;
    assign in_ang[1] = in_data.angle_1;
    assign in_ang[2] = in_data.angle_2;
    assign in_ang[3] = in_data.angle_3;
    assign in_ang[4] = in_data.angle_4;
    assign in_ang[5] = in_data.angle_5;

    assign in_ready  = (st_reg == S_IDLE) && !ov_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign t1        = (thr_reg == '0) ? 15'd1 : thr_reg;

    always_comb
    begin
        mstep = '0;
        for (int j = 0; j < JOINTS; j++)
        begin
            if (in_ang[j] > $signed(lim_reg[j][31:16]))
            begin
                clamp[j] = lim_reg[j][31:16];
            end
            else if (in_ang[j] < $signed(lim_reg[j][15:0]))
            begin
                clamp[j] = lim_reg[j][15:0];
            end
            else
            begin
                clamp[j] = in_ang[j];
            end
            absd[j] = (clamp[j] >= prev_reg[j])
                    ? DIFF_W'(DIFF_W'(clamp[j]) - DIFF_W'(prev_reg[j]))
                    : DIFF_W'(DIFF_W'(prev_reg[j]) - DIFF_W'(clamp[j]));
            if (absd[j] > mstep)
            begin
                mstep = absd[j];
            end
        end
    end

    assign seg_start  = (st_reg == S_SEG);
    assign ctl.start   = lane_start;
    assign ctl.divisor = n_reg;
    assign ctl.k       = k_reg;

    jpci_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seg_start),
        .step  (step_reg),
        .thr   (thr_reg),
        .segs  (segs),
        .done  (seg_done)
    );

    for (genvar g = 0; g < JOINTS; g++)
    begin : g_lane
        jpci_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .prev  (prev_reg[g]),
            .cur   (cur_reg[g]),
            .point (lane_pt[g]),
            .done  (lane_done[g])
        );
    end

    always_comb
    begin
        st_next    = st_reg;
        lane_start = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready && !in_data.first_point)
                begin
                    st_next = (mstep > DIFF_W'(t1)) ? S_SEG : S_OUT;
                end
            end
            S_SEG:  st_next = S_SEGW;
            S_SEGW:
            begin
                if (seg_done)
                begin
                    st_next = (k_reg < segs) ? S_DIV : S_OUT;
                end
            end
            S_DIV:
            begin
                if (k_reg < n_reg)
                begin
                    lane_start = !ov_reg;
                    st_next    = ov_reg ? S_DIV : S_WAIT;
                end
                else
                begin
                    st_next = S_OUT;
                end
            end
            S_WAIT:
            begin
                if (&lane_done)
                begin
                    st_next = S_DIV;
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            ov_reg  <= 1'b0;
            thr_reg <= 15'd410;
            k_reg   <= '0;
            n_reg   <= '0;
            for (int j = 0; j < JOINTS; j++)
            begin
                lim_reg[j]  <= 32'h7FFF8000;
                prev_reg[j] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < REG_THRESHOLD)
                begin
                    lim_reg[cfg_index] <= cfg_data;
                end
                else if (cfg_index == REG_THRESHOLD)
                begin
                    thr_reg <= cfg_data[14:0];
                end
            end
            if (out_valid && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (st_reg == S_IDLE && in_valid && in_ready && in_data.first_point)
            begin
                ov_reg <= 1'b1;
                od_reg <= {in_data.angle_0, in_data.angle_1, in_data.angle_2,
                           in_data.angle_3, in_data.angle_4, in_data.angle_5,
                           1'b0, 1'b1};
                for (int j = 0; j < JOINTS; j++)
                begin
                    prev_reg[j] <= in_ang[j];
                end
            end
            if (st_reg == S_IDLE && in_valid && in_ready)
            begin
                k_reg <= SEG_W'(1);
            end
            if (st_reg == S_SEGW && seg_done)
            begin
                n_reg <= segs;
            end
            if (st_reg == S_WAIT && (&lane_done))
            begin
                ov_reg <= 1'b1;
                od_reg <= {lane_pt[0], lane_pt[1], lane_pt[2], lane_pt[3],
                           lane_pt[4], lane_pt[5], 1'b1, 1'b0};
                k_reg  <= k_reg + 1'b1;
            end
            if (st_reg == S_OUT && !ov_reg)
            begin
                ov_reg <= 1'b1;
                od_reg <= {cur_reg[0], cur_reg[1], cur_reg[2], cur_reg[3],
                           cur_reg[4], cur_reg[5], 1'b0, 1'b1};
                for (int j = 0; j < JOINTS; j++)
                begin
                    prev_reg[j] <= cur_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && in_valid && in_ready)
        begin
            step_reg <= mstep;
            for (int j = 0; j < JOINTS; j++)
            begin
                cur_reg[j] <= clamp[j];
            end
        end
    end

    // An item is taken only while no result is pending.
    a_in_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !out_valid)
        else $error("Input transfer while a result is pending.");

    // The lanes start together and only with a free output register.
    a_lane_start: assert property (@(posedge clk) disable iff (!rst_n)
        lane_start |-> (!ov_reg && (&lane_done)))
        else $error("Lane start with busy lanes or full output.");

    // An interpolated result is never marked as the last one.
    a_interp_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.interpolated && out_data.last))
        else $error("Interpolated result marked last.");

endmodule

FILE: hdl/jpci_lane.sv
module jpci_lane
    import jpci_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lane_ctl_t                 ctl,
    input  logic signed [ANGLE_W-1:0] prev,
    input  logic signed [ANGLE_W-1:0] cur,
    output logic signed [ANGLE_W-1:0] point,
    output logic                      done
);

    // Restoring divider of |k*d| by n, one quotient bit per cycle.
    localparam int CNT_W = $clog2(QDIV_W + 1);

    logic [QDIV_W-1:0]   rem_reg, rem_next;
    logic [QDIV_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic                busy_reg, busy_next;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]   mag;
    logic [PROD_W-1:0]   prod;
    logic [QDIV_W:0]     trial;
    logic [QDIV_W-1:0]   shifted;
    logic signed [DIFF_W:0] qs;

    always_comb
    begin
        diff     = DIFF_W'(cur) - DIFF_W'(prev);
        mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
        prod     = PROD_W'(mag) * PROD_W'(ctl.k);
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        shifted  = {rem_reg[QDIV_W-2:0], quo_reg[QDIV_W-1]};
        trial    = {1'b0, shifted} - {{(QDIV_W+1-SEG_W){1'b0}}, ctl.divisor};
        if (ctl.start)
        begin
            rem_next  = '0;
            quo_next  = prod;
            cnt_next  = CNT_W'(QDIV_W);
            neg_next  = diff[DIFF_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[QDIV_W])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[QDIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[QDIV_W-1:0];
                quo_next = {quo_reg[QDIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        qs    = neg_reg ? -(DIFF_W+1)'(quo_reg[DIFF_W-1:0])
                        : (DIFF_W+1)'(quo_reg[DIFF_W-1:0]);
        point = ANGLE_W'(qs + (DIFF_W+1)'(prev));
        done  = !busy_reg;
    end

endmodule

FILE: hdl/jpci_step.sv
module jpci_step
    import jpci_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIFF_W-1:0]         step,
    input  logic [14:0]               thr,
    output logic [SEG_W-1:0]          segs,
    output logic                      done
);

    // Segment count by repeated subtraction of the threshold, capped at MAX_SEGMENTS.
    logic [DIFF_W:0]     rem_reg, rem_next;
    logic [SEG_W-1:0]    n_reg, n_next;
    logic                busy_reg, busy_next;
    logic [14:0]         t;

    always_comb
    begin
        t         = (thr == '0) ? 15'd1 : thr;
        rem_next  = rem_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = {1'b0, step};
            n_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg == '0 || n_reg == SEG_W'(MAX_SEGMENTS))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                n_next = n_reg + 1'b1;
                if (rem_reg > (DIFF_W+1)'(t))
                begin
                    rem_next = rem_reg - (DIFF_W+1)'(t);
                end
                else
                begin
                    rem_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
            rem_reg  <= rem_next;
        end
    end

    assign segs = n_reg;
    assign done = !busy_reg;

endmodule
